// ===== hw/rtl/g6d_pkg.sv =====
// Shared types and constants for the graph6 edge decoder.
// No dependencies; imported by every module of the decoder.
package g6d_pkg;

   localparam int SYM_W   = 8;
   localparam int VERT_W  = 6;
   localparam int KIND_W  = 2;
   localparam int BITS_W  = 6;
   localparam int STEP_W  = 3;
   localparam int PAIR_W  = 11;

   localparam logic [SYM_W-1:0] HEADER_BIAS    = 8'd63;
   localparam logic [SYM_W-1:0] LONG_FORM_MARK = 8'd126;
   localparam int               TOP_BIT        = 5;

   localparam logic [KIND_W-1:0] KIND_EDGE   = 2'd0;
   localparam logic [KIND_W-1:0] KIND_HEADER = 2'd1;
   localparam logic [KIND_W-1:0] KIND_ERROR  = 2'd2;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   typedef enum logic [1:0] {
      OP_HEADER = 2'd0,
      OP_ERROR  = 2'd1,
      OP_DATA   = 2'd2
   } op_type;

   // One classified transaction handed from the front to the back.
   typedef struct packed {
      op_type              op;
      logic [VERT_W-1:0]   vcount;
      logic [BITS_W-1:0]   bits;
      logic [STEP_W-1:0]   steps;
   } cmd_type;

   // Queue status seen by the front.
   typedef struct packed {
      logic full;
   } qstat_type;

   // Queue head seen by the back.
   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } qhead_type;

endpackage

// ===== hw/rtl/g6d_front.sv =====
// Front end: accepts graph6 characters, classifies headers and data,
// tracks the remaining pair budget and pushes commands. Uses g6d_pkg.
module g6d_front import g6d_pkg::*; #(
   parameter int MAX_VERTICES = 62
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [SYM_W-1:0]   req_symbol,
   input  logic               req_graph_start,
   input  qstat_type          qstat,
   output logic               push,
   output cmd_type            push_cmd
);

   logic              active_ff, active_in;
   logic [PAIR_W-1:0] pairs_left_ff, pairs_left_in;

   logic              accept;
   logic [SYM_W-1:0]  sym_off;
   logic              header_ok;
   logic [VERT_W-1:0] nverts;
   logic [PAIR_W-1:0] header_pairs;
   logic [STEP_W-1:0] steps;
   logic [BITS_W-1:0] mask;

   assign req_stall = qstat.full;
   assign accept    = req_valid && !qstat.full;
   assign sym_off   = req_symbol - HEADER_BIAS;
   assign nverts    = sym_off[VERT_W-1:0];

   assign header_ok = (req_symbol >= HEADER_BIAS) && (req_symbol != LONG_FORM_MARK) &&
                      ({24'd0, sym_off} <= 32'(MAX_VERTICES));

   // n*(n-1)/2 pairs in the upper triangle
   always_comb begin
      logic [2*VERT_W-1:0] prod;
      prod = (nverts == '0) ? '0 : nverts * (nverts - VERT_W'(1));
      header_pairs = PAIR_W'(prod >> 1);
   end

   assign steps = (pairs_left_ff >= PAIR_W'(BITS_W)) ? STEP_W'(BITS_W)
                                                       : pairs_left_ff[STEP_W-1:0];

   // keep only the bits that land on a remaining pair
   always_comb begin
      for (int b = 0; b < BITS_W; b++) begin
         mask[b] = (STEP_W'(TOP_BIT - b) < steps);
      end
   end

   always_comb begin
      active_in       = active_ff;
      pairs_left_in   = pairs_left_ff;
      push            = 1'b0;
      push_cmd.op     = OP_DATA;
      push_cmd.vcount = nverts;
      push_cmd.bits   = sym_off[BITS_W-1:0] & mask;
      push_cmd.steps  = steps;
      if (accept) begin
         if (req_graph_start) begin
            push = 1'b1;
            if (header_ok) begin
               push_cmd.op   = OP_HEADER;
               active_in     = 1'b1;
               pairs_left_in = header_pairs;
            end else begin
               push_cmd.op   = OP_ERROR;
               active_in     = 1'b0;
               pairs_left_in = '0;
            end
         end else if (active_ff && steps != '0) begin
            push          = 1'b1;
            pairs_left_in = pairs_left_ff - PAIR_W'(steps);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff     <= 1'b0;
         pairs_left_ff <= '0;
      end else begin
         active_ff     <= active_in;
         pairs_left_ff <= pairs_left_in;
      end
   end

endmodule

// ===== hw/rtl/g6d_queue.sv =====
// Short command queue between the front and the back of the decoder.
// Uses g6d_pkg for the command type and depth.
module g6d_queue import g6d_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  cmd_type   push_cmd,
   input  logic      pop,
   output qstat_type qstat,
   output qhead_type qhead
);

   cmd_type           mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]   count_ff, count_in;

   assign qstat.full  = (count_ff == (QPTR_W+1)'(QUEUE_DEPTH));
   assign qhead.valid = (count_ff != '0);
   assign qhead.cmd   = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ===== hw/rtl/g6d_back.sv =====
// Back end: walks the pair triangle one bit per cycle while the result channel is
// not stalled, and drives the registered result channel. Uses g6d_pkg.
module g6d_back import g6d_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  qhead_type         qhead,
   output logic              pop,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [KIND_W-1:0] rsp_kind,
   output logic [VERT_W-1:0] rsp_vertex_count,
   output logic [VERT_W-1:0] rsp_edge_low,
   output logic [VERT_W-1:0] rsp_edge_high,
   output logic              rsp_last
);

   logic              busy_ff, busy_in;
   logic [BITS_W-1:0] bits_ff, bits_in;
   logic [STEP_W-1:0] steps_ff, steps_in;
   logic [VERT_W-1:0] vert_ff, vert_in;
   logic [VERT_W-1:0] row_ff, row_in;
   logic [VERT_W-1:0] col_ff, col_in;

   logic              out_valid_ff, out_valid_in;
   logic [KIND_W-1:0] kind_ff, kind_in;
   logic [VERT_W-1:0] vc_ff, vc_in;
   logic [VERT_W-1:0] lo_ff, lo_in;
   logic [VERT_W-1:0] hi_ff, hi_in;
   logic              last_ff, last_in;

   logic advance;
   logic cur_bit;
   logic rest_zero;
   logic last_step;

   assign advance   = !out_valid_ff || !rsp_stall;
   assign cur_bit   = bits_ff[TOP_BIT];
   assign rest_zero = (bits_ff[TOP_BIT-1:0] == '0);
   assign last_step = (steps_ff == STEP_W'(1));

   // take the next command when idle, or once the current walk is on its final step
   // and the result slot is not claimed twice
   assign pop = advance && qhead.valid &&
                (!busy_ff || (last_step && (!cur_bit || qhead.cmd.op == OP_DATA)));

   always_comb begin
      busy_in      = busy_ff;
      bits_in      = bits_ff;
      steps_in     = steps_ff;
      vert_in      = vert_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      out_valid_in = out_valid_ff;
      kind_in      = kind_ff;
      vc_in        = vc_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      last_in      = last_ff;
      if (advance) begin
         out_valid_in = 1'b0;
         if (busy_ff) begin
            if (cur_bit) begin
               out_valid_in = 1'b1;
               kind_in      = KIND_EDGE;
               vc_in        = vert_ff;
               lo_in        = row_ff;
               hi_in        = col_ff;
               last_in      = rest_zero;
            end
            bits_in  = {bits_ff[BITS_W-2:0], 1'b0};
            steps_in = steps_ff - STEP_W'(1);
            if (row_ff + VERT_W'(1) == col_ff) begin
               row_in = '0;
               col_in = col_ff + VERT_W'(1);
            end else begin
               row_in = row_ff + VERT_W'(1);
            end
            if (last_step) begin
               busy_in = 1'b0;
            end
         end
         if (pop) begin
            unique case (qhead.cmd.op)
               OP_HEADER: begin
                  vert_in      = qhead.cmd.vcount;
                  row_in       = '0;
                  col_in       = VERT_W'(1);
                  out_valid_in = 1'b1;
                  kind_in      = KIND_HEADER;
                  vc_in        = qhead.cmd.vcount;
                  lo_in        = '0;
                  hi_in        = '0;
                  last_in      = 1'b1;
               end
               OP_ERROR: begin
                  out_valid_in = 1'b1;
                  kind_in      = KIND_ERROR;
                  vc_in        = '0;
                  lo_in        = '0;
                  hi_in        = '0;
                  last_in      = 1'b1;
               end
               OP_DATA: begin
                  busy_in  = 1'b1;
                  bits_in  = qhead.cmd.bits;
                  steps_in = qhead.cmd.steps;
               end
               default: begin
                  busy_in = busy_in;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
         vert_ff      <= '0;
         row_ff       <= '0;
         col_ff       <= VERT_W'(1);
      end else begin
         busy_ff      <= busy_in;
         out_valid_ff <= out_valid_in;
         vert_ff      <= vert_in;
         row_ff       <= row_in;
         col_ff       <= col_in;
      end
   end

   always_ff @(posedge clock) begin
      bits_ff  <= bits_in;
      steps_ff <= steps_in;
      kind_ff  <= kind_in;
      vc_ff    <= vc_in;
      lo_ff    <= lo_in;
      hi_ff    <= hi_in;
      last_ff  <= last_in;
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_kind         = kind_ff;
   assign rsp_vertex_count = vc_ff;
   assign rsp_edge_low     = lo_ff;
   assign rsp_edge_high    = hi_ff;
   assign rsp_last         = last_ff;

endmodule

// ===== hw/rtl/graph6_edge_decoder_top.sv =====
// Channel  Direction  Handshake             Payload
// req      in         req_valid/req_stall   req_symbol, req_graph_start
// rsp      out        rsp_valid/rsp_stall   rsp_kind, rsp_vertex_count, rsp_edge_low,
//                                           rsp_edge_high, rsp_last
//
// A data character covers up to 6 remaining pairs, which the back end visits with
// its one-bit-per-cycle pair walk.
// The front accepts a character every cycle while the 4-entry queue has room.
// Reset is synchronous and clears the walk, the queue and the result register.
// rsp_stall holds a valid result in the register and freezes the walk; req_stall rises when
// the queue is full. Depends on g6d_pkg, g6d_front, g6d_queue and g6d_back.
module graph6_edge_decoder_top import g6d_pkg::*; #(
   parameter int MAX_VERTICES = 62
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [SYM_W-1:0]  req_symbol,
   input  logic              req_graph_start,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [KIND_W-1:0] rsp_kind,
   output logic [VERT_W-1:0] rsp_vertex_count,
   output logic [VERT_W-1:0] rsp_edge_low,
   output logic [VERT_W-1:0] rsp_edge_high,
   output logic              rsp_last
);

   qstat_type qstat;
   qhead_type qhead;
   logic      push;
   cmd_type   push_cmd;
   logic      pop;

   g6d_front #(
      .MAX_VERTICES (MAX_VERTICES)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_symbol      (req_symbol),
      .req_graph_start (req_graph_start),
      .qstat           (qstat),
      .push            (push),
      .push_cmd        (push_cmd)
   );

   g6d_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .qstat    (qstat),
      .qhead    (qhead)
   );

   g6d_back u_back (
      .clock            (clock),
      .reset            (reset),
      .qhead            (qhead),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_kind         (rsp_kind),
      .rsp_vertex_count (rsp_vertex_count),
      .rsp_edge_low     (rsp_edge_low),
      .rsp_edge_high    (rsp_edge_high),
      .rsp_last         (rsp_last)
   );

endmodule

// ===== tb/tb_graph6_edge_decoder_top.sv =====
// Self-checking testbench for graph6_edge_decoder_top: directed and random graph6
// character streams with random gaps and stalls, checked against a built-in predictor.
// Depends on g6d_pkg and graph6_edge_decoder_top.
`timescale 1ns / 100ps

module tb_graph6_edge_decoder_top;
   import g6d_pkg::*;

   localparam int MAX_VERTS    = 62;
   localparam int RANDOM_ITEMS = 140;
   localparam int QUIET_AFTER  = 115;
   localparam int DRAIN_CYCLES = 24;

   typedef struct {
      logic [KIND_W-1:0] kind;
      logic [VERT_W-1:0] vcount;
      logic [VERT_W-1:0] lo;
      logic [VERT_W-1:0] hi;
      logic              last;
   } graph_result_type;

   // Tracks the pair walk and holds the edges and headers still owed by the block.
   class edge_scoreboard;
      logic [VERT_W-1:0] vertices;
      logic [VERT_W-1:0] row;
      logic [6:0]        col;
      logic              active;
      graph_result_type  owed_q[$];
      int                errors;
      int                live_chars;
      int                graphs;
      int                n_edges;
      int                n_headers;
      int                n_bad_headers;

      function new();
         vertices = '0;
         row = '0;
         col = 7'd1;
         active = 1'b0;
         errors = 0;
         live_chars = 0;
         graphs = 0;
         n_edges = 0;
         n_headers = 0;
         n_bad_headers = 0;
      endfunction

      function void note_char(logic [SYM_W-1:0] sym, logic start);
         graph_result_type batch[6];
         graph_result_type r;
         logic [SYM_W-1:0] diff;
         logic [BITS_W-1:0] bits;
         int count;
         count = 0;
         r = '{kind: KIND_EDGE, vcount: '0, lo: '0, hi: '0, last: 1'b1};
         if (start) begin
            live_chars++;
            row = '0;
            col = 7'd1;
            if (sym < HEADER_BIAS || sym == LONG_FORM_MARK ||
                int'(sym) - int'(HEADER_BIAS) > MAX_VERTS) begin
               active = 1'b0;
               vertices = '0;
               r.kind = KIND_ERROR;
            end else begin
               active = 1'b1;
               vertices = VERT_W'(sym - HEADER_BIAS);
               r.kind = KIND_HEADER;
               r.vcount = vertices;
               graphs++;
            end
            owed_q.push_back(r);
            return;
         end
         // drop data characters while no graph is open
         if (!active)
            return;
         live_chars++;
         diff = sym - HEADER_BIAS;
         bits = diff[BITS_W-1:0];
         for (int b = TOP_BIT; b >= 0; b--) begin
            if (int'(col) >= int'(vertices))
               break;
            if (bits[b]) begin
               batch[count] = '{kind: KIND_EDGE, vcount: vertices, lo: row,
                                hi: VERT_W'(col), last: 1'b0};
               count++;
            end
            row++;
            if (7'(row) == col) begin
               col++;
               row = '0;
            end
         end
         if (count > 0)
            batch[count-1].last = 1'b1;
         for (int k = 0; k < count; k++)
            owed_q.push_back(batch[k]);
      endfunction

      function void compare_field(string name, logic [7:0] want, logic [7:0] got);
         if (got !== want) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            errors++;
         end
      endfunction

      function void check_result(logic [KIND_W-1:0] kind, logic [VERT_W-1:0] vcount,
                                 logic [VERT_W-1:0] lo, logic [VERT_W-1:0] hi,
                                 logic last);
         graph_result_type want;
         if (owed_q.size() == 0) begin
            $error("rsp transaction with nothing pending: kind %0d (%0d,%0d)", kind, lo, hi);
            errors++;
            return;
         end
         want = owed_q.pop_front();
         compare_field("rsp_kind", 8'(want.kind), 8'(kind));
         compare_field("rsp_vertex_count", 8'(want.vcount), 8'(vcount));
         compare_field("rsp_edge_low", 8'(want.lo), 8'(lo));
         compare_field("rsp_edge_high", 8'(want.hi), 8'(hi));
         compare_field("rsp_last", 8'(want.last), 8'(last));
         case (want.kind)
            KIND_EDGE:   n_edges++;
            KIND_HEADER: n_headers++;
            default:     n_bad_headers++;
         endcase
      endfunction
   endclass

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   logic [SYM_W-1:0]  req_symbol = '0;
   logic              req_graph_start = 1'b0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   logic [KIND_W-1:0] rsp_kind;
   logic [VERT_W-1:0] rsp_vertex_count;
   logic [VERT_W-1:0] rsp_edge_low;
   logic [VERT_W-1:0] rsp_edge_high;
   logic              rsp_last;

   edge_scoreboard sb;
   bit quiet = 1'b0;
   int stall_left = 0;

   graph6_edge_decoder_top #(.MAX_VERTICES(MAX_VERTS)) dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_symbol       (req_symbol),
      .req_graph_start  (req_graph_start),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_kind         (rsp_kind),
      .rsp_vertex_count (rsp_vertex_count),
      .rsp_edge_low     (rsp_edge_low),
      .rsp_edge_high    (rsp_edge_high),
      .rsp_last         (rsp_last)
   );

   always #10 clock = ~clock;

   // Stall the result channel in bursts until the quiet tail of the run.
   always @(posedge clock) begin
      if (stall_left > 0)
         stall_left--;
      else if (!reset && !quiet && $urandom_range(0, 7) == 0)
         stall_left = $urandom_range(1, 19);
      rsp_stall <= (stall_left > 0);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_result(rsp_kind, rsp_vertex_count, rsp_edge_low, rsp_edge_high,
                         rsp_last);
   end

   // Present one character, hold it until the transaction completes, then log it.
   task automatic send_char(input logic [SYM_W-1:0] sym, input logic start);
      if (!quiet && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_symbol <= sym;
      req_graph_start <= start;
      do @(posedge clock); while (req_stall);
      sb.note_char(sym, start);
   endtask

   function automatic logic [SYM_W-1:0] pick_data();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0)
         return SYM_W'(HEADER_BIAS);
      if (r == 1)
         return SYM_W'(LONG_FORM_MARK);
      if (r == 2)
         return SYM_W'($urandom_range(0, 255));
      return SYM_W'($urandom_range(63, 126));
   endfunction

   task automatic send_graph();
      int n;
      int r;
      int nbytes;
      r = $urandom_range(0, 9);
      if (r < 6)
         n = $urandom_range(0, 8);
      else if (r < 9)
         n = $urandom_range(9, 20);
      else
         n = $urandom_range(21, MAX_VERTS);
      nbytes = (n * (n - 1) / 2 + 5) / 6;
      // mostly complete graphs; some cut short, some with trailing characters
      r = $urandom_range(0, 7);
      if (r == 0)
         nbytes = $urandom_range(0, nbytes);
      else if (r == 1)
         nbytes += $urandom_range(1, 3);
      if (nbytes > 48)
         nbytes = 48;
      send_char(SYM_W'(int'(HEADER_BIAS) + n), 1'b1);
      for (int k = 0; k < nbytes; k++)
         send_char(pick_data(), 1'b0);
   endtask

   task automatic send_noise();
      repeat ($urandom_range(1, 4))
         send_char(SYM_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
   endtask

   initial begin
      int base;
      sb = new();
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // directed: no graph open, bad headers, empty graphs, full walks, off-range data
      send_char(8'd126, 1'b0);
      send_char(8'd0, 1'b1);
      send_char(8'd62, 1'b1);
      send_char(8'd126, 1'b1);
      send_char(8'd255, 1'b1);
      send_char(8'd100, 1'b0);
      send_char(8'd63, 1'b1);
      send_char(8'd126, 1'b0);
      send_char(8'd64, 1'b1);
      send_char(8'd126, 1'b0);
      send_char(8'd67, 1'b1);
      send_char(8'd126, 1'b0);
      send_char(8'd126, 1'b0);
      send_char(8'd68, 1'b1);
      send_char(8'd63, 1'b0);
      send_char(8'd200, 1'b0);
      send_char(8'd255, 1'b0);
      send_char(8'd125, 1'b1);
      send_char(8'd126, 1'b0);
      send_char(8'd0, 1'b0);
      send_char(8'd1, 1'b0);
      send_char(8'd65, 1'b1);
      send_char(8'd96, 1'b0);

      base = sb.live_chars;
      while (sb.live_chars - base < RANDOM_ITEMS) begin
         if (sb.live_chars - base >= QUIET_AFTER)
            quiet = 1'b1;
         if ($urandom_range(0, 9) < 8)
            send_graph();
         else
            send_noise();
      end
      quiet = 1'b1;
      req_valid <= 1'b0;

      while (sb.owed_q.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d characters over %0d graphs; checked %0d edges, %0d headers,",
               sb.live_chars, sb.graphs, sb.n_edges, sb.n_headers);
      $display("and %0d rejected headers, with random gaps and result stalls.",
               sb.n_bad_headers);
      if (sb.errors == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

   initial begin
      #5_000_000;
      $display("TB_ERROR");
      $finish;
   end

endmodule

// ===== sim.f =====
hw/rtl/g6d_pkg.sv
hw/rtl/g6d_front.sv
hw/rtl/g6d_queue.sv
hw/rtl/g6d_back.sv
hw/rtl/graph6_edge_decoder_top.sv
tb/tb_graph6_edge_decoder_top.sv
